// ----- design/lnds_pkg.sv -----
// Package for the longest non-decreasing subsequence length block.
// Holds the pile memory sizing, the request and result structs, and the FSM state type.
// No dependencies.
`default_nettype none

package lnds_pkg;

  localparam int MAX_PILES = 64;
  localparam int IDX_W     = $clog2(MAX_PILES);
  localparam int CNT_W     = $clog2(MAX_PILES + 1);
  localparam int VAL_W     = 8;
  localparam int LEN_W     = 7;
  localparam int LEN_MAX   = (1 << LEN_W) - 1;
  localparam int CMP_W     = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    first;
    logic                    final_req;
  } in_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic             overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CMP,
    ST_WRITE,
    ST_EMIT
  } lnds_state_t;

endpackage

`default_nettype wire

// ----- design/longest_nondecreasing_subseq_length.sv -----
// Top level of the longest non-decreasing subsequence length block (patience sorting).
// Pile tops live in a single-port synchronous memory searched by binary search.
// Depends on lnds_pkg.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------
//   in      | into      | in_valid, in_stall | in_item  (value, first, final_req)
//   out     | out of    | out_valid,out_stall| out_item (length, overflow)
//
// A request runs a binary search of at most k = ceil(log2(n + 1)) steps over the n piles
// it searches, none after a first mark; a final request then loads the result. Each
// search step reads the pile memory once. Reset clears the pile count, the overflow flag
// and the result valid flag; the pile memory is not cleared. A stalled result is held in
// its register while the next request is taken; a final request then waits until the
// register frees.
`default_nettype none

module longest_nondecreasing_subseq_length (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire lnds_pkg::in_item_t in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output lnds_pkg::out_item_t     out_item
);
  import lnds_pkg::*;

  lnds_state_t state, state_next;

  // Pile-top memory: sorted non-decreasing over the valid piles.
  logic signed [VAL_W-1:0] pile_mem [MAX_PILES];
  logic signed [VAL_W-1:0] rd_data;
  logic        [IDX_W-1:0] rd_addr;
  logic                    rd_en;
  logic                    wr_en;
  logic        [IDX_W-1:0] wr_addr;

  logic [CNT_W-1:0]        pile_count;
  logic                    overflow_seen;
  in_item_t                req;
  logic [CNT_W-1:0]        lo;
  logic [CNT_W-1:0]        hi;
  logic [CNT_W-1:0]        mid;
  logic [CNT_W:0]          mid_sum;

  logic                    accept;
  logic                    out_free;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign mid_sum  = {1'b0, lo} + {1'b0, hi};

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    rd_addr    = mid_sum[IDX_W:1];
    wr_addr    = lo[IDX_W-1:0];
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (lo < hi) begin
          rd_en      = 1'b1;
          state_next = ST_CMP;
        end else begin
          state_next = ST_WRITE;
        end
      end
      ST_CMP: begin
        state_next = ST_SEARCH;
      end
      ST_WRITE: begin
        // A slot below the count replaces a top; at the count it opens a pile if room is left.
        wr_en      = (lo < pile_count) || (pile_count < CNT_W'(MAX_PILES));
        state_next = req.final_req ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= pile_mem[rd_addr];
    end
    if (wr_en) begin
      pile_mem[wr_addr] <= req.value;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= in_item;
      lo  <= '0;
      hi  <= in_item.first ? '0 : pile_count;
    end else if (state == ST_SEARCH && lo < hi) begin
      mid <= mid_sum[CNT_W:1];
    end else if (state == ST_CMP) begin
      if (rd_data > req.value) begin
        hi <= mid;
      end else begin
        lo <= mid + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pile_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (accept && in_item.first) begin
      pile_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (state == ST_WRITE && lo == pile_count) begin
      if (pile_count < CNT_W'(MAX_PILES)) begin
        pile_count <= pile_count + CNT_W'(1);
      end else begin
        overflow_seen <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      out_item.length   <= (CMP_W'(pile_count) > CMP_W'(LEN_MAX)) ?
                           LEN_W'(LEN_MAX) : LEN_W'(pile_count);
      out_item.overflow <= overflow_seen;
    end
  end

  // The pile count never passes the memory depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    pile_count <= CNT_W'(MAX_PILES))
    else $error("pile count exceeds memory depth");

  // The search window never inverts and never reaches past the valid piles.
  a_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH || state == ST_CMP || state == ST_WRITE) |->
      (lo <= hi && hi <= pile_count))
    else $error("binary search window out of order");

  // An accepted request always starts a search.
  a_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_SEARCH)
    else $error("accepted request did not start a search");

  // Opening a pile raises the count by exactly one.
  a_new_pile: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE && lo == pile_count && pile_count < CNT_W'(MAX_PILES)) |=>
      pile_count == $past(pile_count) + CNT_W'(1))
    else $error("new pile did not raise the count");

  // A result is loaded only from the emit state.
  a_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_EMIT)
    else $error("result appeared outside the emit state");

endmodule

`default_nettype wire

// ----- bench/tb_longest_nondecreasing_subseq_length.sv -----
`timescale 1ns / 100ps
// Testbench for longest_nondecreasing_subseq_length: drives marked sequences of signed
// values and checks each reported length and overflow flag against a pile scoreboard.
// Depends on lnds_pkg and the block's RTL.

module tb_longest_nondecreasing_subseq_length;
  import lnds_pkg::*;

  localparam int NUM_REQUESTS = 1800;
  localparam int CALM_TAIL    = 300;
  localparam int HOLD_AT      = 600;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 40;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 8'sh80;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 8'sh7F;

  // Patience sorting over signed tops; a value replaces the first top greater than it, so an equal top never takes it.
  class pile_scoreboard;
    logic signed [VAL_W-1:0] tops [MAX_PILES];
    int                      pile_count;
    bit                      overflow_seen;
    out_item_t               lengths_q [$];
    int unsigned             errors;
    int unsigned             checked;
    int unsigned             overflow_results;

    function new();
      pile_count = 0;
      overflow_seen = 1'b0;
      errors = 0;
      checked = 0;
      overflow_results = 0;
    endfunction

    function void note_request(in_item_t req);
      logic signed [VAL_W-1:0] v;
      bit                      placed;
      int                      i;
      out_item_t               res;
      v = req.value;
      placed = 1'b0;
      if (req.first) begin
        pile_count = 0;
        overflow_seen = 1'b0;
      end
      for (i = 0; i < pile_count && !placed; i++) begin
        if (tops[i] > v) begin
          tops[i] = v;
          placed = 1'b1;
        end
      end
      if (!placed) begin
        if (pile_count < MAX_PILES) begin
          tops[pile_count] = v;
          pile_count++;
        end else begin
          overflow_seen = 1'b1;
        end
      end
      if (req.final_req) begin
        res.length = LEN_W'((pile_count > LEN_MAX) ? LEN_MAX : pile_count);
        res.overflow = overflow_seen;
        lengths_q.push_back(res);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (lengths_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, length %0d overflow %0b",
                 $time, got.length, got.overflow);
        return;
      end
      want = lengths_q.pop_front();
      checked++;
      if (want.overflow) overflow_results++;
      if (got.length !== want.length) begin
        errors++;
        $display("%0t: length mismatch, expected %0d actual %0d",
                 $time, want.length, got.length);
      end
      if (got.overflow !== want.overflow) begin
        errors++;
        $display("%0t: overflow mismatch, expected %0b actual %0b",
                 $time, want.overflow, got.overflow);
      end
    endfunction
  endclass

  logic           clk;
  logic           rst;
  logic           in_valid;
  logic           in_stall;
  in_item_t       in_req;
  logic           out_valid;
  logic           out_stall;
  out_item_t      result;

  pile_scoreboard sb = new();
  bit             gaps_on;
  bit             hold_request;
  bit             hold_done;
  int unsigned    sent;
  int unsigned    idle_cycles;

  longest_nondecreasing_subseq_length DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (result)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Ends the run if neither channel moves for too long.
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, IDLE_LIMIT, sb.lengths_q.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  task automatic send_request(input logic signed [VAL_W-1:0] value, input bit first,
                              input bit fin);
    in_item_t req;
    req.value = value;
    req.first = first;
    req.final_req = fin;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (in_stall);
    sb.note_request(req);
    sent++;
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return 8'sh00;
      3: return 8'shFF;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  task automatic random_sequence();
    int kind;
    int n;
    int k;
    int level;
    kind = $urandom_range(0, 19);
    if (kind < 12) begin
      n = $urandom_range(1, 24);
      for (k = 0; k < n; k++) send_request(pick_value(), k == 0, k == n - 1);
    end else if (kind < 14) begin
      // A slow climb fills the piles; the longer ones run past the limit.
      n = $urandom_range(MAX_PILES - 4, MAX_PILES + 6);
      level = $urandom_range(-128, -100);
      for (k = 0; k < n; k++) begin
        level = level + $urandom_range(0, 3);
        if (level > 127) level = 127;
        send_request(VAL_W'(level), k == 0, k == n - 1);
      end
    end else if (kind < 16) begin
      // Carries on from the previous sequence.
      n = $urandom_range(1, 8);
      for (k = 0; k < n; k++) send_request(pick_value(), 1'b0, k == n - 1);
    end else if (kind < 18) begin
      n = $urandom_range(1, 10);
      for (k = 0; k < n; k++)
        send_request(pick_value(), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
    end else begin
      // Opened but never closed; a later final request reports it only if no first mark comes before it.
      n = $urandom_range(1, 12);
      for (k = 0; k < n; k++) send_request(pick_value(), k == 0, 1'b0);
    end
  endtask

  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) sb.check_result(result);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && gaps_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_req = '0;
    out_stall = 1'b0;
    gaps_on = 1'b1;
    hold_request = 1'b0;
    hold_done = 1'b0;
    sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset leaves an empty sequence, so no first mark is needed here.
    send_request(8'sd5, 1'b0, 1'b1);
    send_request(VAL_MIN, 1'b1, 1'b1);
    send_request(VAL_MAX, 1'b1, 1'b1);
    // Top values stack on equal tops and are never out of range.
    send_request(VAL_MAX, 1'b1, 1'b0);
    send_request(VAL_MAX, 1'b0, 1'b0);
    send_request(VAL_MIN, 1'b0, 1'b0);
    send_request(VAL_MAX, 1'b0, 1'b1);
    send_request(8'sd3, 1'b1, 1'b0);
    send_request(8'sd2, 1'b0, 1'b0);
    send_request(8'sd1, 1'b0, 1'b1);
    // Requests after a final one extend the same sequence.
    send_request(8'sd0, 1'b0, 1'b1);
    send_request(8'sd5, 1'b0, 1'b1);
    send_request(8'sd10, 1'b1, 1'b0);
    send_request(8'sd20, 1'b0, 1'b0);
    send_request(8'sd30, 1'b1, 1'b0);
    send_request(8'sd40, 1'b0, 1'b1);
    send_request(8'shFF, 1'b1, 1'b0);
    send_request(8'shAA, 1'b0, 1'b0);
    send_request(8'shFF, 1'b0, 1'b0);
    send_request(8'sh55, 1'b0, 1'b1);

    while (sent < NUM_REQUESTS) begin
      if (sent >= NUM_REQUESTS - CALM_TAIL) gaps_on = 1'b0;
      if (!hold_done && sent >= HOLD_AT) begin
        hold_request = 1'b1;
        hold_done = 1'b1;
      end
      random_sequence();
    end
    in_valid <= 1'b0;

    while (sb.lengths_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests; %0d lengths checked, %0d of them with pile overflow.",
             sent, sb.checked, sb.overflow_results);
    $display("Included a %0d-cycle result hold and %0d mismatches were seen.",
             HOLD_CYCLES, sb.errors);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
